>>> rtl/u8cp_pkg.sv
// ----------------------------------------------------------------------------
// u8cp_pkg
// Shared types and constants for the UTF-8 to code page converter.
// ----------------------------------------------------------------------------
package u8cp_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int CODE_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int ENTRY_W = CODE_W + CHAR_W;
    localparam int COUNT_W = 9;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic KIND_CONVERT = 1'b0;
    localparam logic KIND_TABLE   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

endpackage

>>> rtl/u8cp_ram.sv
// ----------------------------------------------------------------------------
// u8cp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module u8cp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/utf8_to_codepage_converter.sv
// ----------------------------------------------------------------------------
// utf8_to_codepage_converter
// Decodes UTF-8 bytes and maps finished code points to one-byte characters.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries either a byte to convert (kind 0)
// or a write into the mapping table (kind 1). A table write produces no
// output; every converted byte produces exactly one out_char transfer.
// ASCII bytes, lead bytes, non-final continuations and invalid bytes have
// their result registered and shown on the next cycle. The final
// continuation of a sequence, when the entry count is nonzero, starts a
// bisection over the sorted table held in a single RAM with a registered
// read; with a zero entry count the final continuation gives 0 directly.
// in_ready is high while no search runs and the output register is empty or
// being emptied in the same cycle; a stalled receiver holds out_char and
// blocks further input after one item. Reset clears the decode state, the
// entry count and the output valid flag; table contents stay undefined until
// written. entry_count is written over the APB port at addresses 0 to 3.
// ----------------------------------------------------------------------------
module utf8_to_codepage_converter #(
    parameter int TABLE_DEPTH = u8cp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8cp_pkg::ADDR_W-1:0]   paddr,
    input  logic [u8cp_pkg::DATA_W-1:0]   pwdata,
    output logic [u8cp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [7:0]                    byte_in,
    input  logic [7:0]                    entry_index,
    input  logic [u8cp_pkg::CODE_W-1:0]   entry_code,
    input  logic [u8cp_pkg::CHAR_W-1:0]   entry_char,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8cp_pkg::CHAR_W-1:0]   out_char
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    u8cp_pkg::state_t state_reg, state_next;

    logic [u8cp_pkg::CODE_W-1:0]  acc_reg, acc_next;
    logic [1:0]                   rem_reg, rem_next;
    logic [u8cp_pkg::CODE_W-1:0]  key_reg, key_next;
    logic [CW-1:0]                lo_reg, lo_next;
    logic [CW-1:0]                hi_reg, hi_next;
    logic                         out_valid_reg, out_valid_next;
    logic [u8cp_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [u8cp_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    logic [u8cp_pkg::ENTRY_W-1:0] ram_wr_data;
    logic                         ram_rd_en;
    logic [AW-1:0]                ram_rd_addr;
    logic [u8cp_pkg::ENTRY_W-1:0] ram_rd_data;

    logic                         in_fire;
    logic                         cfg_write;
    logic                         start_search;
    logic                         search_done;
    logic [CW-1:0]                count_clamp;
    logic [u8cp_pkg::CODE_W-1:0]  acc_shift;
    logic [CW:0]                  probe_sum;
    logic [CW-1:0]                probe_mid;
    logic [u8cp_pkg::CODE_W-1:0]  probe_code;
    logic [CW-1:0]                nlo;
    logic [CW-1:0]                nhi;
    logic [CW:0]                  next_sum;

    u8cp_ram #(
        .WIDTH (u8cp_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[u8cp_pkg::ADDR_W-1] == u8cp_pkg::REG_ENTRY_COUNT)
                       ? u8cp_pkg::DATA_W'(count_reg) : '0;

    assign in_ready  = (state_reg == u8cp_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;

    assign count_clamp = (32'(count_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_reg);
    assign acc_shift   = {acc_reg[u8cp_pkg::CODE_W-7:0], byte_in[5:0]};
    assign probe_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign probe_mid   = probe_sum[CW:1];
    assign probe_code  = ram_rd_data[u8cp_pkg::ENTRY_W-1:u8cp_pkg::CHAR_W];
    assign nlo         = (key_reg > probe_code) ? CW'(probe_mid + 1'b1) : lo_reg;
    assign nhi         = (key_reg < probe_code) ? probe_mid : hi_reg;
    assign next_sum    = {1'b0, nlo} + {1'b0, nhi};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            u8cp_pkg::ST_IDLE:
            begin
                if (start_search)
                begin
                    state_next = u8cp_pkg::ST_SEARCH;
                end
            end
            u8cp_pkg::ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = u8cp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = u8cp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        count_next     = count_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = AW'(entry_index);
        ram_wr_data    = {entry_code, entry_char};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = AW'(count_clamp >> 1);
        start_search   = 1'b0;
        search_done    = 1'b0;

        if (cfg_write && (paddr[u8cp_pkg::ADDR_W-1] == u8cp_pkg::REG_ENTRY_COUNT))
        begin
            count_next = pwdata[u8cp_pkg::COUNT_W-1:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            u8cp_pkg::ST_IDLE:
            begin
                if (in_fire && (kind == u8cp_pkg::KIND_TABLE))
                begin
                    ram_wr_en = (32'(entry_index) < TABLE_DEPTH);
                end
                else if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    if (!byte_in[7])
                    begin
                        acc_next      = '0;
                        rem_next      = 2'd0;
                        out_char_next = byte_in;
                    end
                    else if (byte_in[7:5] == 3'b110)
                    begin
                        acc_next = u8cp_pkg::CODE_W'(byte_in[4:0]);
                        rem_next = 2'd1;
                    end
                    else if (byte_in[7:4] == 4'b1110)
                    begin
                        acc_next = u8cp_pkg::CODE_W'(byte_in[3:0]);
                        rem_next = 2'd2;
                    end
                    else if (byte_in[7:3] == 5'b11110)
                    begin
                        acc_next = u8cp_pkg::CODE_W'(byte_in[2:0]);
                        rem_next = 2'd3;
                    end
                    else if ((byte_in[7:6] == 2'b10) && (rem_reg != 2'd0))
                    begin
                        rem_next = rem_reg - 2'd1;
                        acc_next = acc_shift;
                        if (rem_reg == 2'd1)
                        begin
                            acc_next = '0;
                            key_next = acc_shift;
                            if (count_clamp != '0)
                            begin
                                out_valid_next = 1'b0;
                                lo_next        = '0;
                                hi_next        = count_clamp;
                                ram_rd_en      = 1'b1;
                                start_search   = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        acc_next = '0;
                        rem_next = 2'd0;
                    end
                end
            end
            u8cp_pkg::ST_SEARCH:
            begin
                if (key_reg == probe_code)
                begin
                    search_done    = 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = ram_rd_data[u8cp_pkg::CHAR_W-1:0];
                end
                else if (nlo < nhi)
                begin
                    lo_next     = nlo;
                    hi_next     = nhi;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(next_sum[CW:1]);
                end
                else
                begin
                    search_done    = 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                end
            end
            default:
            begin
                search_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= u8cp_pkg::ST_IDLE;
            acc_reg       <= '0;
            rem_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        out_char_reg <= out_char_next;
    end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to code page converter. A directed table
// covers the byte classes, sequence breaks, accumulator wrap and table edges.
// Randomised phases then follow, each after an entry count write, with
// mostly well-formed UTF-8 over a loaded sorted table, noise and rewrites.
// Every out_char transfer is checked in order against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH        = u8cp_pkg::TABLE_DEPTH_DEF;
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 196;
    localparam int CALM_PHASE   = 3;
    localparam int PRESS_PHASE  = 4;
    localparam int DIR_ROWS     = 26;

    typedef enum logic {
        ROW_SEND,
        ROW_COUNT
    } row_act_t;

    typedef struct packed {
        logic                          kind;
        logic [7:0]                    byte_v;
        logic [7:0]                    idx;
        logic [u8cp_pkg::CODE_W-1:0]   code;
        logic [u8cp_pkg::CHAR_W-1:0]   chr;
        logic                          typed;
        logic [u8cp_pkg::CHAR_W-1:0]   want;
    } xfer_t;

    typedef struct packed {
        row_act_t act;
        xfer_t    x;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [u8cp_pkg::ADDR_W-1:0]   paddr;
    logic [u8cp_pkg::DATA_W-1:0]   pwdata;
    logic [u8cp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic                          kind;
    logic [7:0]                    byte_in;
    logic [7:0]                    entry_index;
    logic [u8cp_pkg::CODE_W-1:0]   entry_code;
    logic [u8cp_pkg::CHAR_W-1:0]   entry_char;
    logic                          out_valid;
    logic                          out_ready;
    logic [u8cp_pkg::CHAR_W-1:0]   out_char;

    xfer_t                         cur_xfer;
    xfer_t                         stim_q[$];
    logic [u8cp_pkg::CHAR_W-1:0]   pending_chars[$];
    dir_row_t                      directed_rows [DIR_ROWS];

    logic [u8cp_pkg::CODE_W-1:0]   seq_code;
    logic [1:0]                    seq_left;
    logic [u8cp_pkg::CODE_W-1:0]   xlat_code [DEPTH];
    logic [u8cp_pkg::CHAR_W-1:0]   xlat_char [DEPTH];
    int unsigned                   xlat_count;

    logic [u8cp_pkg::CODE_W-1:0]   gen_keys [DEPTH];
    int unsigned                   gen_lim;

    int                            idle_pct;
    bit                            hold_req;
    int                            fail_count;
    int                            cycles;

    utf8_to_codepage_converter #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .byte_in     (byte_in),
        .entry_index (entry_index),
        .entry_code  (entry_code),
        .entry_char  (entry_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %0h, got %0h (cycle %0d)", what, want, got, cycles);
        fail_count++;
    endtask

    function automatic logic [u8cp_pkg::CHAR_W-1:0] bisect_table(
        input logic [u8cp_pkg::CODE_W-1:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = (xlat_count > DEPTH) ? DEPTH : xlat_count;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (key < xlat_code[mid])
                hi = mid;
            else if (key > xlat_code[mid])
                lo = mid + 1;
            else
                return xlat_char[mid];
        end
        return '0;
    endfunction

    task automatic predict_out_char(input xfer_t x);
        logic [u8cp_pkg::CHAR_W-1:0] res;
        bit                          gives;
        res   = '0;
        gives = 1'b1;
        if (x.kind == u8cp_pkg::KIND_TABLE)
        begin
            gives = 1'b0;
            if (int'(x.idx) < DEPTH)
            begin
                xlat_code[x.idx] = x.code;
                xlat_char[x.idx] = x.chr;
            end
        end
        else if (!x.byte_v[7])
        begin
            seq_code = '0;
            seq_left = '0;
            res      = x.byte_v;
        end
        else if (x.byte_v[7:5] == 3'b110)
        begin
            seq_code = {11'b0, x.byte_v[4:0]};
            seq_left = 2'd1;
        end
        else if (x.byte_v[7:4] == 4'b1110)
        begin
            seq_code = {12'b0, x.byte_v[3:0]};
            seq_left = 2'd2;
        end
        else if (x.byte_v[7:3] == 5'b11110)
        begin
            seq_code = {13'b0, x.byte_v[2:0]};
            seq_left = 2'd3;
        end
        else if (x.byte_v[7:6] == 2'b10 && seq_left != 2'd0)
        begin
            seq_code = {seq_code[9:0], x.byte_v[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                res      = bisect_table(seq_code);
                seq_code = '0;
            end
        end
        else
        begin
            seq_code = '0;
            seq_left = '0;
        end
        if (gives)
            pending_chars.push_back(x.typed ? x.want : res);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_chars.size() == 0)
                    report_mismatch("out_char with nothing pending", 32'h0, 32'(out_char));
                else if (out_char !== pending_chars[0])
                    report_mismatch("out_char", 32'(pending_chars[0]), 32'(out_char));
                if (pending_chars.size() != 0)
                    void'(pending_chars.pop_front());
            end
            if (in_valid && in_ready)
                predict_out_char(cur_xfer);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TIMEOUT after %0d cycles, %0d results pending", cycles,
                     pending_chars.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : rx_side
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_queued();
        xfer_t x;
        @(negedge clk);
        while (stim_q.size() != 0)
        begin
            x = stim_q.pop_front();
            while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            cur_xfer    = x;
            kind        <= x.kind;
            byte_in     <= x.byte_v;
            entry_index <= x.idx;
            entry_code  <= x.code;
            entry_char  <= x.chr;
            in_valid    <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain_block();
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [u8cp_pkg::COUNT_W-1:0] value);
        logic [u8cp_pkg::ADDR_W-1:0] addr;
        addr = u8cp_pkg::ADDR_W'(4 * int'(u8cp_pkg::REG_ENTRY_COUNT));
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= u8cp_pkg::DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        xlat_count = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== u8cp_pkg::DATA_W'(value))
            report_mismatch("entry_count readback", u8cp_pkg::DATA_W'(value), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_convert(input logic [7:0] b);
        xfer_t x;
        x        = xfer_t'($urandom());
        x.kind   = u8cp_pkg::KIND_CONVERT;
        x.byte_v = b;
        x.code   = u8cp_pkg::CODE_W'($urandom_range(65535));
        x.typed  = 1'b0;
        stim_q.push_back(x);
    endtask

    task automatic queue_entry(input logic [7:0] idx,
                               input logic [u8cp_pkg::CODE_W-1:0] code,
                               input logic [u8cp_pkg::CHAR_W-1:0] chr);
        xfer_t x;
        x        = '0;
        x.kind   = u8cp_pkg::KIND_TABLE;
        x.byte_v = 8'($urandom_range(255));
        x.idx    = idx;
        x.code   = code;
        x.chr    = chr;
        stim_q.push_back(x);
        gen_keys[idx] = code;
    endtask

    task automatic queue_code_point(input logic [u8cp_pkg::CODE_W-1:0] cp, input int len);
        logic [20:0] v;
        if (len == 2 && cp < 16'h0800)
        begin
            queue_convert({3'b110, cp[10:6]});
            queue_convert({2'b10, cp[5:0]});
        end
        else if (len == 4)
        begin
            // upper bits fall off the 16-bit accumulator
            v = {5'($urandom_range(31)), cp};
            queue_convert({5'b11110, v[20:18]});
            queue_convert({2'b10, v[17:12]});
            queue_convert({2'b10, v[11:6]});
            queue_convert({2'b10, v[5:0]});
        end
        else
        begin
            queue_convert({4'b1110, cp[15:12]});
            queue_convert({2'b10, cp[11:6]});
            queue_convert({2'b10, cp[5:0]});
        end
    endtask

    task automatic queue_random_phase(input int n);
        int r;
        int len;
        int k;
        int idx;
        while (stim_q.size() < n)
        begin
            r = $urandom_range(99);
            if (r < 55)
                queue_code_point(gen_keys[$urandom_range(gen_lim - 1)], $urandom_range(2, 4));
            else if (r < 65)
                queue_code_point(u8cp_pkg::CODE_W'($urandom_range(65535)),
                                 $urandom_range(2, 4));
            else if (r < 78)
                queue_convert(8'($urandom_range(127)));
            else if (r < 86)
                queue_convert(8'($urandom_range(255)));
            else if (r < 92)
            begin
                len = $urandom_range(3, 4);
                queue_convert(len == 3 ? 8'hE0 | 8'($urandom_range(15))
                                       : 8'hF0 | 8'($urandom_range(7)));
                k = $urandom_range(len - 2);
                repeat (k) queue_convert(8'h80 | 8'($urandom_range(63)));
            end
            else if (r < 97)
            begin
                idx = $urandom_range(DEPTH - 1);
                queue_entry(8'(idx), u8cp_pkg::CODE_W'(idx * 256 + $urandom_range(255)),
                            8'($urandom_range(255)));
            end
            else
                queue_entry(8'($urandom_range(255)),
                            u8cp_pkg::CODE_W'($urandom_range(65535)),
                            8'($urandom_range(255)));
        end
    endtask

    initial
    begin : main
        int unsigned phase_counts [PHASES];
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        kind        = u8cp_pkg::KIND_CONVERT;
        byte_in     = '0;
        entry_index = '0;
        entry_code  = '0;
        entry_char  = '0;
        cur_xfer    = '0;
        seq_code    = '0;
        seq_left    = '0;
        xlat_count  = 0;
        gen_lim     = DEPTH;
        idle_pct    = 21;
        hold_req    = 1'b0;
        fail_count  = 0;
        cycles      = 0;

        directed_rows = '{
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h7F, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h7F}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hC4, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h85, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h80, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hFF, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_TABLE,   8'h00, 8'h00, 16'h0000, 8'hFF, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_TABLE,   8'hFF, 8'h01, 16'h0105, 8'hB9, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_TABLE,   8'h00, 8'h02, 16'h20AC, 8'h80, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_TABLE,   8'h00, 8'h03, 16'hFFFF, 8'h01, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_TABLE,   8'h00, 8'hFF, 16'hFFFF, 8'hAA, 1'b0, 8'h00}},
            // code field carries the new entry count
            '{ROW_COUNT, '{u8cp_pkg::KIND_CONVERT, 8'h00, 8'h00, 16'h0004, 8'h00, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hF0, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hC4, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h85, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hE2, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h82, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hAC, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hF0, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h41, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h41}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hF4, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h8F, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hBF, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hBF, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'hC0, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00}},
            '{ROW_SEND,  '{u8cp_pkg::KIND_CONVERT, 8'h80, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00}}
        };
        phase_counts = '{256, 0, 1, 511, 128, 0, 300, 256};
        phase_counts[5] = $urandom_range(2, 255);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].act == ROW_COUNT)
            begin
                send_queued();
                drain_block();
                write_entry_count(directed_rows[i].x.code[u8cp_pkg::COUNT_W-1:0]);
            end
            else
                stim_q.push_back(directed_rows[i].x);
        end
        send_queued();

        // load a full sorted table, one key per 256-wide slot
        for (int i = 0; i < DEPTH; i++)
            queue_entry(8'(i), u8cp_pkg::CODE_W'(i * 256 + $urandom_range(255)),
                        8'($urandom_range(255)));
        send_queued();

        for (int p = 0; p < PHASES; p++)
        begin
            drain_block();
            write_entry_count(u8cp_pkg::COUNT_W'(phase_counts[p]));
            gen_lim  = (phase_counts[p] == 0) ? DEPTH
                     : (phase_counts[p] > DEPTH) ? DEPTH : phase_counts[p];
            idle_pct = (p == CALM_PHASE) ? 0 : 21;
            if (p == PRESS_PHASE)
                hold_req = 1'b1;
            queue_random_phase(PHASE_ITEMS);
            send_queued();
        end

        drain_block();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
